>>> sv/smi_pkg.sv
// Package for the small matrix inverse block: default widths, size codes,
// the per-item control struct and the cofactor index tables.
// No dependencies.
package smi_pkg;

	// Default data format: signed Q16.16.
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Matrix size code carried by every item.
	typedef enum logic {
		SIZE_2X2 = 1'b0,
		SIZE_3X3 = 1'b1
	} size_t;

	// Control that travels with one item between the parts.
	typedef struct packed {
		logic  valid;
		size_t size;
	} item_ctl_t;

	// Cofactor k of the 3x3 adjugate is a[P]*a[Q] - a[R]*a[S], where the
	// element index is row*3 + column.
	localparam int COF_P [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int COF_Q [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int COF_R [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int COF_S [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

>>> sv/smi_div.sv
// Pipelined restoring divider: one quotient bit per stage, one division
// entering per cycle. Gives QW quotient bits and a flag when the quotient
// needs more than QW bits. No package dependency.
module smi_div #(
	parameter int NW  = 64,
	parameter int DMW = 96,
	parameter int QW  = 32
) (
	input  logic           clk,
	input  logic [NW-1:0]  num,
	input  logic [DMW-1:0] den,
	output logic [QW-1:0]  q,
	output logic           hi
);
	localparam int HW = NW - QW;
	localparam int XW = ((HW > DMW) ? HW : DMW) + 1;

	logic [DMW-1:0] rem_s [QW+1];
	logic [DMW-1:0] den_s [QW+1];
	logic [QW-1:0]  low_s [QW+1];
	logic [QW-1:0]  q_s   [QW+1];
	logic           hi_s  [QW+1];

	logic [XW-1:0] hx;
	logic [XW-1:0] dx;
	logic          ge0;

	// Upper part of the numerator against the divisor: at or above it the
	// quotient does not fit in QW bits.
	always_comb begin
		hx  = XW'(num[NW-1:QW]);
		dx  = XW'(den);
		ge0 = (hx >= dx);
	end

	always_ff @(posedge clk) begin
		hi_s[0]  <= ge0;
		rem_s[0] <= ge0 ? '0 : hx[DMW-1:0];
		low_s[0] <= num[QW-1:0];
		q_s[0]   <= '0;
		den_s[0] <= den;
	end

	// One shift, compare and subtract per stage.
	for (genvar i = 1; i <= QW; i++) begin : g_stage
		logic [DMW:0] sh;
		logic [DMW:0] diff;
		logic         ge;

		always_comb begin
			sh   = {rem_s[i-1], low_s[i-1][QW-1]};
			diff = sh - {1'b0, den_s[i-1]};
			ge   = (sh >= {1'b0, den_s[i-1]});
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? diff[DMW-1:0] : sh[DMW-1:0];
			low_s[i] <= low_s[i-1] << 1;
			q_s[i]   <= {q_s[i-1][QW-2:0], ge};
			hi_s[i]  <= hi_s[i-1];
			den_s[i] <= den_s[i-1];
		end
	end

	assign q  = q_s[QW];
	assign hi = hi_s[QW];

endmodule

>>> sv/smi_fifo.sv
// Short register queue between the front and the back of the inverse block.
// Generic in width and depth. No package dependency.
module smi_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             not_empty
);
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q;
	logic [PTRW-1:0]  rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == CNTW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign dout      = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNTW'(do_push) - CNTW'(do_pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

>>> sv/smi_front.sv
// Front of the inverse block: accepts an item, forms the 2x2 products and
// the adjugate entries, and hands them on with the first row.
// Depends on smi_pkg.
module smi_front #(
	parameter int W = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    func,
	input  logic [8:0][W-1:0]       a_in,
	input  logic                    stall,
	output smi_pkg::item_ctl_t      out_ctl,
	output logic [8:0][2*W:0]       cof_out,
	output logic [2:0][W-1:0]       row_out
);
	import smi_pkg::*;

	localparam int PW = 2 * W;
	localparam int CW = 2 * W + 1;

	logic en;
	logic v_s1, v_s2, v_s3;
	size_t size_s1, size_s2, size_s3;
	logic [8:0][W-1:0]    a_s1;
	logic signed [PW-1:0] prod_c  [18];
	logic signed [PW-1:0] prod_s2 [18];
	logic [3:0][W-1:0]    m2_s2;
	logic [2:0][W-1:0]    row_s2, row_s3;
	logic [8:0][CW-1:0]   cof_c, cof_s3;

	function automatic logic [CW-1:0] sx(input logic [W-1:0] v);
		return {{(CW-W){v[W-1]}}, v};
	endfunction

	// The whole front advances unless the queue is full.
	assign en   = !stall;
	assign busy = stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Products of element pairs, one per cofactor term.
	for (genvar k = 0; k < 9; k++) begin : g_prod
		assign prod_c[2*k]   = $signed(a_s1[COF_P[k]]) * $signed(a_s1[COF_Q[k]]);
		assign prod_c[2*k+1] = $signed(a_s1[COF_R[k]]) * $signed(a_s1[COF_S[k]]);
	end

	// Adjugate entries; the 2x2 case swaps and negates elements directly.
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			cof_c[k] = {prod_s2[2*k][PW-1], prod_s2[2*k]}
				- {prod_s2[2*k+1][PW-1], prod_s2[2*k+1]};
		end
		if (size_s2 == SIZE_2X2) begin
			cof_c    = '0;
			cof_c[0] = sx(m2_s2[3]);
			cof_c[1] = '0 - sx(m2_s2[1]);
			cof_c[3] = '0 - sx(m2_s2[2]);
			cof_c[4] = sx(m2_s2[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			size_s1 <= size_t'(func);
			a_s1    <= a_in;
			size_s2 <= size_s1;
			prod_s2 <= prod_c;
			m2_s2   <= {a_s1[4], a_s1[3], a_s1[1], a_s1[0]};
			row_s2  <= a_s1[2:0];
			size_s3 <= size_s2;
			cof_s3  <= cof_c;
			row_s3  <= row_s2;
		end
	end

	assign out_ctl.valid = v_s3;
	assign out_ctl.size  = size_s3;
	assign cof_out       = cof_s3;
	assign row_out       = row_s3;

endmodule

>>> sv/smi_back.sv
// Back of the inverse block: determinant, magnitudes, nine pipelined
// divisions and saturation into the result registers.
// Depends on smi_pkg and smi_div.
module smi_back #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  smi_pkg::item_ctl_t  in_ctl,
	input  logic [8:0][2*W:0]   cof_in,
	input  logic [2:0][W-1:0]   row_in,
	output logic                done,
	output logic [8:0][W-1:0]   inv,
	output logic [W-1:0]        det_out,
	output logic                singular,
	output logic                overflow
);
	import smi_pkg::*;

	localparam int CW   = 2 * W + 1;
	localparam int CMW  = 2 * W;
	localparam int DETW = 3 * W + 2;
	localparam int DMW  = 3 * W;
	localparam int NW   = CMW + 2 * F;
	localparam int DLY  = W + 1;
	localparam int SW   = 2 + W + 9;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic v_b1, v_b2, v_b3, v_b4;
	size_t size_b1, size_b2, size_b3;

	logic signed [2*W:0] pl_c [3];
	logic signed [2*W:0] ph_c [3];
	logic signed [2*W:0] pl_b1 [3];
	logic signed [2*W:0] ph_b1 [3];
	logic [8:0][CMW-1:0] cmag_c, cmag_b1, cmag_b2, cmag_b3;
	logic [8:0]          csg_c, csg_b1, csg_b2, csg_b3;
	logic [2:0][DETW-1:0] prod_c, prod_b2;
	logic [DETW-1:0]     det_c, det_b3;

	logic            dneg;
	logic [DETW-1:0] dabs;
	logic [DMW-1:0]  dsh;
	logic            dov;
	logic [W-1:0]    dval;

	logic [8:0][NW-1:0] num_b4;
	logic [DMW-1:0]     den_b4;
	logic [SW-1:0]      side_b4;

	logic [8:0][W-1:0] q_d;
	logic [8:0]        hi_d;
	logic [SW-1:0]     side_d [DLY];
	logic              vld_d  [DLY];

	logic [8:0][W-1:0] inv_c;
	logic [8:0]        ov_c;
	logic              sing_f, dov_f;
	logic [W-1:0]      dval_f;
	logic [8:0]        qsg_f;

	logic               done_q, singular_q, overflow_q;
	logic [8:0][W-1:0]  inv_q;
	logic [W-1:0]       det_out_q;

	// Valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1   <= 1'b0;
			v_b2   <= 1'b0;
			v_b3   <= 1'b0;
			v_b4   <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < DLY; i++) begin
				vld_d[i] <= 1'b0;
			end
		end else begin
			v_b1     <= in_ctl.valid;
			v_b2     <= v_b1;
			v_b3     <= v_b2;
			v_b4     <= v_b3;
			vld_d[0] <= v_b4;
			for (int i = 1; i < DLY; i++) begin
				vld_d[i] <= vld_d[i-1];
			end
			done_q <= vld_d[DLY-1];
		end
	end

	// First-row products split over the low and high halves of each cofactor.
	for (genvar k = 0; k < 3; k++) begin : g_rowmul
		assign pl_c[k] = $signed(row_in[k]) * $signed({1'b0, cof_in[3*k][W-1:0]});
		assign ph_c[k] = $signed(row_in[k]) * $signed(cof_in[3*k][CW-1:W]);
	end

	// Sign and magnitude of each adjugate entry.
	always_comb begin
		logic [CW-1:0] t;
		for (int k = 0; k < 9; k++) begin
			csg_c[k]  = cof_in[k][CW-1];
			t         = csg_c[k] ? ('0 - cof_in[k]) : cof_in[k];
			cmag_c[k] = t[CMW-1:0];
		end
	end

	// Recombine the split products and sum them into the determinant.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod_c[k] = ({{(DETW-CW){ph_b1[k][2*W]}}, ph_b1[k]} << W)
				+ {{(DETW-CW){pl_b1[k][2*W]}}, pl_b1[k]};
		end
		det_c = prod_b2[0] + prod_b2[1] + prod_b2[2];
	end

	// Determinant magnitude and the saturated determinant output.
	always_comb begin
		dneg = det_b3[DETW-1];
		dabs = dneg ? ('0 - det_b3) : det_b3;
		dsh  = (size_b3 == SIZE_3X3) ? (dabs[DMW-1:0] >> (2 * F)) : (dabs[DMW-1:0] >> F);
		if (dneg) begin
			dov  = (|dsh[DMW-1:W]) || (dsh[W-1] && (|dsh[W-2:0]));
			dval = dov ? MINV : ('0 - dsh[W-1:0]);
		end else begin
			dov  = |dsh[DMW-1:W-1];
			dval = dov ? MAXV : dsh[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		size_b1 <= in_ctl.size;
		pl_b1   <= pl_c;
		ph_b1   <= ph_c;
		cmag_b1 <= cmag_c;
		csg_b1  <= csg_c;
		size_b2 <= size_b1;
		prod_b2 <= prod_c;
		cmag_b2 <= cmag_b1;
		csg_b2  <= csg_b1;
		size_b3 <= size_b2;
		det_b3  <= det_c;
		cmag_b3 <= cmag_b2;
		csg_b3  <= csg_b2;
		den_b4  <= dabs[DMW-1:0];
		for (int k = 0; k < 9; k++) begin
			num_b4[k] <= {cmag_b3[k], {(2*F){1'b0}}};
		end
		side_b4 <= {(det_b3 == '0), dov, dval, csg_b3 ^ {9{dneg}}};
	end

	// Nine dividers, one per inverse element.
	for (genvar k = 0; k < 9; k++) begin : g_div
		smi_div #(
			.NW (NW),
			.DMW(DMW),
			.QW (W)
		) u_div (
			.clk(clk),
			.num(num_b4[k]),
			.den(den_b4),
			.q  (q_d[k]),
			.hi (hi_d[k])
		);
	end

	// Side data waits alongside the dividers.
	always_ff @(posedge clk) begin
		side_d[0] <= side_b4;
		for (int i = 1; i < DLY; i++) begin
			side_d[i] <= side_d[i-1];
		end
	end

	// Saturate each quotient with its sign.
	always_comb begin
		{sing_f, dov_f, dval_f, qsg_f} = side_d[DLY-1];
		for (int k = 0; k < 9; k++) begin
			if (qsg_f[k]) begin
				ov_c[k]  = hi_d[k] || (q_d[k][W-1] && (|q_d[k][W-2:0]));
				inv_c[k] = ov_c[k] ? MINV : ('0 - q_d[k]);
			end else begin
				ov_c[k]  = hi_d[k] || q_d[k][W-1];
				inv_c[k] = ov_c[k] ? MAXV : q_d[k];
			end
		end
	end

	// Result registers; a singular matrix gives zeros.
	always_ff @(posedge clk) begin
		singular_q <= sing_f;
		overflow_q <= !sing_f && ((|ov_c) || dov_f);
		inv_q      <= sing_f ? '0 : inv_c;
		det_out_q  <= sing_f ? '0 : dval_f;
	end

	assign done     = done_q;
	assign inv      = inv_q;
	assign det_out  = det_out_q;
	assign singular = singular_q;
	assign overflow = overflow_q;

endmodule

>>> sv/small_matrix_inverse.sv
// Small matrix inverse (2x2 or 3x3, signed fixed point) by adjugate and determinant.
// Throughput: one item per cycle; the nine pipelined dividers set the depth.
// The receiver cannot stall, so busy stays low in operation.
// Reset clears all valid bits; data registers are not reset.
// Depends on smi_pkg, smi_front, smi_fifo, smi_back and smi_div.
module small_matrix_inverse #(
	parameter int DATA_WIDTH = smi_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = smi_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic [DATA_WIDTH-1:0] a00,
	input  logic [DATA_WIDTH-1:0] a01,
	input  logic [DATA_WIDTH-1:0] a02,
	input  logic [DATA_WIDTH-1:0] a10,
	input  logic [DATA_WIDTH-1:0] a11,
	input  logic [DATA_WIDTH-1:0] a12,
	input  logic [DATA_WIDTH-1:0] a20,
	input  logic [DATA_WIDTH-1:0] a21,
	input  logic [DATA_WIDTH-1:0] a22,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] inv00,
	output logic [DATA_WIDTH-1:0] inv01,
	output logic [DATA_WIDTH-1:0] inv02,
	output logic [DATA_WIDTH-1:0] inv10,
	output logic [DATA_WIDTH-1:0] inv11,
	output logic [DATA_WIDTH-1:0] inv12,
	output logic [DATA_WIDTH-1:0] inv20,
	output logic [DATA_WIDTH-1:0] inv21,
	output logic [DATA_WIDTH-1:0] inv22,
	output logic [DATA_WIDTH-1:0] det_out,
	output logic                  singular,
	output logic                  overflow
);
	import smi_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int CW = 2 * W + 1;
	localparam int EW = 1 + 9 * CW + 3 * W;

	logic [8:0][W-1:0]  a_in;
	item_ctl_t          f_ctl;
	logic [8:0][CW-1:0] f_cof;
	logic [2:0][W-1:0]  f_row;
	logic               q_full;
	logic               q_ne;
	logic [EW-1:0]      q_dout;
	item_ctl_t          b_ctl;
	logic [8:0][CW-1:0] b_cof;
	logic [2:0][W-1:0]  b_row;
	logic [8:0][W-1:0]  inv;

	assign a_in = {a22, a21, a20, a12, a11, a10, a02, a01, a00};

	// Front: accept and form the adjugate.
	smi_front #(
		.W(W)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.func   (func),
		.a_in   (a_in),
		.stall  (q_full),
		.out_ctl(f_ctl),
		.cof_out(f_cof),
		.row_out(f_row)
	);

	// Queue between front and back; the back drains one item per cycle.
	smi_fifo #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_ctl.valid),
		.din      ({f_ctl.size, f_cof, f_row}),
		.pop      (q_ne),
		.dout     (q_dout),
		.full     (q_full),
		.not_empty(q_ne)
	);

	assign b_ctl.valid = q_ne;
	assign {b_ctl.size, b_cof, b_row} = q_dout;

	// Back: determinant, divisions, saturation.
	smi_back #(
		.W(W),
		.F(FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (b_ctl),
		.cof_in  (b_cof),
		.row_in  (b_row),
		.done    (done),
		.inv     (inv),
		.det_out (det_out),
		.singular(singular),
		.overflow(overflow)
	);

	assign {inv22, inv21, inv20, inv12, inv11, inv10, inv02, inv01, inv00} = inv;

endmodule
